### hw/rtl/per_key_min_interval_monitor_top_macros.svh
// Assertion helpers for the interval monitor.
// Both forms sample on the rising clock and are disabled while reset is low.
`ifndef PER_KEY_MIN_INTERVAL_MONITOR_TOP_MACROS_SVH
`define PER_KEY_MIN_INTERVAL_MONITOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PKMIM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PKMIM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/pkmim_pkg.sv
package pkmim_pkg;

    // Default sizing of the key table.
    localparam int ENTRIES_DEF  = 32;
    localparam int KEY_BITS_DEF = 16;

    // Fixed field widths.
    localparam int KEY_IN_W   = 16;
    localparam int TICK_W     = 32;
    localparam int THRESH_W   = 20;
    localparam int COUNT_W    = 16;
    localparam int SLOT_OUT_W = 5;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(3000);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    // Verdict codes on the result word.
    typedef enum logic [1:0] {
        V_EXISTING  = 2'd0,
        V_NEW       = 2'd1,
        V_UNTRACKED = 2'd2,
        V_ALERT     = 2'd3
    } t_verdict;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CMP
    } t_state;

endpackage

### hw/rtl/per_key_min_interval_monitor_top.sv
// Channel   Direction  Handshake                  Word
// in        input      i_in_valid / o_in_ready    i_event_key, i_now_tick
// out       output     o_out_valid / i_out_ready  o_verdict, o_repeat_count, o_slot_index
// cfg       input      i_cfg_we (no wait)         i_cfg_wdata (threshold in ms)
//
// An input word scans k table slots, k being at least 1 and at most ENTRIES,
// with one table memory read and one compare per slot.
// The threshold compare and the table update share the compare cycle.
// Reset (synchronous, active low) empties the table through the fill count and
// loads the threshold with 3000; no clearing pass is needed.
// A stalled output holds the finishing word in the compare state until taken.
module per_key_min_interval_monitor_top
    import pkmim_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [KEY_IN_W-1:0]   i_event_key,
    input  logic [TICK_W-1:0]     i_now_tick,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_verdict,
    output logic [COUNT_W-1:0]    o_repeat_count,
    output logic [SLOT_OUT_W-1:0] o_slot_index,
    input  logic                  i_cfg_we,
    input  logic [THRESH_W-1:0]   i_cfg_wdata
);

    localparam int KW     = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);

    // Table memory: key, last tick and call count per slot.
    logic [KW-1:0]      key_mem   [ENTRIES];
    logic [TICK_W-1:0]  tick_mem  [ENTRIES];
    logic [COUNT_W-1:0] count_mem [ENTRIES];

    // Control registers.
    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_out_valid, n_out_valid;
    logic [THRESH_W-1:0] r_thr;

    // Working and payload registers.
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [KW-1:0]         r_key, n_key;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [KW-1:0]         r_rd_key;
    logic [TICK_W-1:0]     r_rd_tick;
    logic [COUNT_W-1:0]    r_rd_cnt;
    t_verdict              r_verdict, n_verdict;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [SLOT_OUT_W-1:0] r_slot, n_slot;

    // Memory write port.
    logic               w_en;
    logic [IDX_W-1:0]   w_addr;
    logic [TICK_W-1:0]  w_tick;
    logic [COUNT_W-1:0] w_cnt;

    logic                        hit;
    logic                        more;
    logic                        out_free;
    logic                        too_soon;
    logic [TICK_W-1:0]           diff;
    logic [COUNT_W-1:0]          cnt_inc;
    logic [IDX_W+SLOT_OUT_W-1:0] idx_wide;
    logic [IDX_W+SLOT_OUT_W-1:0] fill_wide;

    // Compare-cycle datapath: key match, wrapped tick difference, saturating count.
    always_comb begin
        hit       = (FILL_W'(r_idx) < r_fill) && (r_rd_key == r_key);
        more      = (FILL_W'(r_idx) + FILL_W'(1)) < r_fill;
        out_free  = !r_out_valid || i_out_ready;
        diff      = r_tick - r_rd_tick;
        too_soon  = diff < {{(TICK_W-THRESH_W){1'b0}}, r_thr};
        cnt_inc   = (r_rd_cnt == COUNT_MAX) ? r_rd_cnt : r_rd_cnt + COUNT_W'(1);
        idx_wide  = {{SLOT_OUT_W{1'b0}}, r_idx};
        fill_wide = {{SLOT_OUT_W{1'b0}}, r_fill[IDX_W-1:0]};
    end

    // Sequencer: next state, table update and result word.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_fill      = r_fill;
        n_key       = r_key;
        n_tick      = r_tick;
        n_out_valid = r_out_valid && !i_out_ready;
        n_verdict   = r_verdict;
        n_count     = r_count;
        n_slot      = r_slot;
        w_en        = 1'b0;
        w_addr      = r_idx;
        w_tick      = r_tick;
        w_cnt       = cnt_inc;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key   = i_event_key[KW-1:0];
                    n_tick  = i_now_tick;
                    n_idx   = '0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!hit && more) begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_FETCH;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (hit) begin
                        n_slot = idx_wide[SLOT_OUT_W-1:0];
                        if (too_soon) begin
                            n_verdict = V_ALERT;
                            n_count   = r_rd_cnt;
                        end else begin
                            w_en      = 1'b1;
                            n_verdict = V_EXISTING;
                            n_count   = cnt_inc;
                        end
                    end else if (r_fill < FILL_W'(ENTRIES)) begin
                        w_en      = 1'b1;
                        w_addr    = r_fill[IDX_W-1:0];
                        w_cnt     = COUNT_W'(1);
                        n_fill    = r_fill + FILL_W'(1);
                        n_verdict = V_NEW;
                        n_count   = COUNT_W'(1);
                        n_slot    = fill_wide[SLOT_OUT_W-1:0];
                    end else begin
                        n_verdict = V_UNTRACKED;
                        n_count   = '0;
                        n_slot    = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and the threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= THRESH_RESET;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    // Working registers and the output word.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_tick    <= n_tick;
        r_verdict <= n_verdict;
        r_count   <= n_count;
        r_slot    <= n_slot;
    end

    // Table memory with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            key_mem[w_addr]   <= r_key;
            tick_mem[w_addr]  <= w_tick;
            count_mem[w_addr] <= w_cnt;
        end
        if (r_state == S_FETCH) begin
            r_rd_key  <= key_mem[r_idx];
            r_rd_tick <= tick_mem[r_idx];
            r_rd_cnt  <= count_mem[r_idx];
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_repeat_count = r_count;
    assign o_slot_index   = r_slot;

    // Checks on the sequencer and the fill count.
`include "per_key_min_interval_monitor_top_macros.svh"

    `PKMIM_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FILL_W'(ENTRIES), "fill count beyond table size")
    `PKMIM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready && (r_state == S_FETCH), "accepted word did not start a scan")
    `PKMIM_ASSERT_NEXT(a_fill_step, 1'b1, (r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + FILL_W'(1)), "fill count moved by more than one")
    `PKMIM_ASSERT_NOW(a_write_only_on_finish, w_en, (r_state == S_CMP) && out_free, "table written outside a finishing compare")

endmodule

### sim/tb_per_key_min_interval_monitor_top.sv
`timescale 1ns / 1ps

module tb_per_key_min_interval_monitor_top;
    import pkmim_pkg::*;

    localparam int HAMMER_WORDS = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 280;

    // One input word as queued for the driver, with the idle cycles to leave before it.
    typedef struct packed {
        logic [KEY_IN_W-1:0] key;
        logic [TICK_W-1:0]   tick;
        logic [7:0]          gap;
    } t_event_word;

    // One result word as the monitor expects to see it.
    typedef struct packed {
        t_verdict              verdict;
        logic [COUNT_W-1:0]    count;
        logic [SLOT_OUT_W-1:0] slot;
    } t_verdict_word;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [KEY_IN_W-1:0]   i_event_key    = '0;
    logic [TICK_W-1:0]     i_now_tick     = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [1:0]            o_verdict;
    logic [COUNT_W-1:0]    o_repeat_count;
    logic [SLOT_OUT_W-1:0] o_slot_index;
    logic                  i_cfg_we       = 1'b0;
    logic [THRESH_W-1:0]   i_cfg_wdata    = '0;

    per_key_min_interval_monitor_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_event_key    (i_event_key),
        .i_now_tick     (i_now_tick),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_verdict      (o_verdict),
        .o_repeat_count (o_repeat_count),
        .o_slot_index   (o_slot_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Words waiting to be sent and verdicts waiting to come back.
    t_event_word   event_q[$];
    t_verdict_word verdict_q[$];

    // Shadow of the key table and threshold, updated as words are accepted.
    logic [KEY_IN_W-1:0] seen_key   [ENTRIES_DEF];
    logic [TICK_W-1:0]   seen_tick  [ENTRIES_DEF];
    logic [COUNT_W-1:0]  seen_count [ENTRIES_DEF];
    int                  seen_fill     = 0;
    logic [THRESH_W-1:0] thresh_model  = THRESH_RESET;

    // Stimulus side: the 32 keys that fill the table and the last tick each one stored.
    logic [KEY_IN_W-1:0] pool_key  [ENTRIES_DEF];
    logic [TICK_W-1:0]   pool_last [ENTRIES_DEF];
    bit                  pool_live [ENTRIES_DEF];
    logic [THRESH_W-1:0] gen_thr = THRESH_RESET;

    int idle_run    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    bit hold_ask    = 1'b0;
    bit hold_seen   = 1'b0;
    bit sink_quiet  = 1'b0;
    int words_sent  = 0;
    int words_seen  = 0;
    int faults      = 0;
    int verdict_tally [4] = '{0, 0, 0, 0};

    // Decide the verdict for one accepted word and update the table shadow.
    function automatic t_verdict_word screen_event(input logic [KEY_IN_W-1:0] key,
                                                   input logic [TICK_W-1:0] now);
        t_verdict_word     r;
        logic [TICK_W-1:0] elapsed;
        int                hit;
        hit = -1;
        for (int s = 0; s < seen_fill; s++) begin
            if (hit < 0 && seen_key[s] == key) begin
                hit = s;
            end
        end
        if (hit >= 0) begin
            elapsed = now - seen_tick[hit];
            r.slot  = SLOT_OUT_W'(hit);
            if (elapsed < TICK_W'(thresh_model)) begin
                // Too soon: the entry keeps its tick and count.
                r.verdict = V_ALERT;
                r.count   = seen_count[hit];
            end else begin
                seen_tick[hit] = now;
                if (seen_count[hit] != COUNT_MAX) begin
                    seen_count[hit] = seen_count[hit] + 1'b1;
                end
                r.verdict = V_EXISTING;
                r.count   = seen_count[hit];
            end
        end else if (seen_fill < ENTRIES_DEF) begin
            seen_key[seen_fill]   = key;
            seen_tick[seen_fill]  = now;
            seen_count[seen_fill] = COUNT_W'(1);
            r.verdict = V_NEW;
            r.count   = COUNT_W'(1);
            r.slot    = SLOT_OUT_W'(seen_fill);
            seen_fill++;
        end else begin
            r.verdict = V_UNTRACKED;
            r.count   = '0;
            r.slot    = '0;
        end
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Interval to the previous stored tick, weighted toward the threshold edge.
    function automatic logic [TICK_W-1:0] pick_interval();
        logic [TICK_W-1:0] thr;
        thr = TICK_W'(gen_thr);
        case ($urandom_range(0, 9))
            0, 1: return thr - 1'b1;
            2, 3: return thr;
            4: return thr + 1'b1;
            5, 6: return $urandom_range(0, thr);
            7: return $urandom;
            8: return -TICK_W'($urandom_range(1, 1000));
            default: return $urandom_range(0, 2 * thr + 2);
        endcase
    endfunction

    function automatic bit in_pool(input logic [KEY_IN_W-1:0] key);
        for (int j = 0; j < ENTRIES_DEF; j++) begin
            if (pool_key[j] == key) return 1'b1;
        end
        return 1'b0;
    endfunction

    // A key that never enters the table.
    function automatic logic [KEY_IN_W-1:0] stray_key();
        logic [KEY_IN_W-1:0] cand;
        do cand = KEY_IN_W'($urandom); while (in_pool(cand));
        return cand;
    endfunction

    task automatic offer_event(input logic [KEY_IN_W-1:0] key, input logic [TICK_W-1:0] tick,
                               input int gap);
        t_event_word w;
        w.key  = key;
        w.tick = tick;
        w.gap  = 8'(gap);
        event_q.push_back(w);
    endtask

    // Queue a word for a table key and track which tick the table will hold for it.
    task automatic offer_tracked(input int k, input logic [TICK_W-1:0] tick, input int gap);
        if (!pool_live[k]) begin
            pool_live[k] = 1'b1;
            pool_last[k] = tick;
        end else if (tick - pool_last[k] >= TICK_W'(gen_thr)) begin
            pool_last[k] = tick;
        end
        offer_event(pool_key[k], tick, gap);
    endtask

    task automatic set_threshold(input logic [THRESH_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= v;
        thresh_model = v;
        gen_thr      = v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
    endtask

    // Wait until every queued word went in and every verdict came back.
    task automatic wait_drained();
        do @(negedge i_clk); while (event_q.size() != 0 || i_in_valid || verdict_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_phase(input logic [THRESH_W-1:0] thr, input bit squeeze);
        int                k;
        logic [KEY_IN_W-1:0] sk;
        set_threshold(thr);
        @(negedge i_clk);
        for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                sk = stray_key();
                offer_event(sk, $urandom, pick_idle());
            end else begin
                k = $urandom_range(0, ENTRIES_DEF - 1);
                offer_tracked(k, pool_last[k] + pick_interval(), pick_idle());
            end
        end
        // Hold the receiver off while the sender keeps offering.
        if (squeeze) hold_ask = ~hold_ask;
        wait_drained();
    endtask

    // Driver: present queued words, record the verdict each accepted word should get.
    always @(posedge i_clk) begin : drive_events
        t_event_word nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            idle_run   = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                verdict_q.push_back(screen_event(i_event_key, i_now_tick));
                words_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (event_q.size() != 0 && idle_run >= int'(event_q[0].gap)) begin
                    nxt = event_q.pop_front();
                    i_event_key <= nxt.key;
                    i_now_tick  <= nxt.tick;
                    i_in_valid  <= 1'b1;
                    idle_run    = 0;
                end else begin
                    i_in_valid <= 1'b0;
                    if (event_q.size() != 0) idle_run++;
                end
            end
        end
    end

    // Long receiver hold-off, started whenever the stimulus side asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each result word with the oldest pending verdict, then pace ready.
    always @(posedge i_clk) begin : check_results
        t_verdict_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                words_seen++;
                verdict_tally[o_verdict]++;
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result: verdict %0d count %0d slot %0d", $time,
                             o_verdict, o_repeat_count, o_slot_index);
                    faults++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_verdict !== want.verdict || o_repeat_count !== want.count ||
                        o_slot_index !== want.slot) begin
                        $display("%0t: expected verdict %0d count %0d slot %0d, got %0d %0d %0d",
                                 $time, want.verdict, want.count, want.slot,
                                 o_verdict, o_repeat_count, o_slot_index);
                        faults++;
                    end
                end
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left  <= stall_left - 1;
            end else begin
                i_out_ready <= 1'b1;
                stall_left  <= sink_quiet ? 0 : pick_idle();
            end
        end
    end

    initial begin : run_test
        logic [KEY_IN_W-1:0] sk;
        logic [KEY_IN_W-1:0] cand;

        // Table keys: the two key extremes plus thirty distinct random ones.
        for (int j = 0; j < ENTRIES_DEF; j++) begin
            pool_key[j]  = '0;
            pool_last[j] = '0;
            pool_live[j] = 1'b0;
        end
        pool_key[2] = '1;
        for (int j = 0; j < ENTRIES_DEF; j++) begin
            if (j != 1 && j != 2) begin
                do cand = KEY_IN_W'($urandom); while (in_pool(cand));
                pool_key[j] = cand;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero threshold, one key hammered back to back with the receiver always ready.
        sink_quiet = 1'b1;
        set_threshold('0);
        @(negedge i_clk);
        for (int n = 0; n < HAMMER_WORDS; n++) begin
            offer_tracked(0, $urandom, 0);
        end
        wait_drained();
        sink_quiet = 1'b0;

        // Directed words at the reset threshold.
        set_threshold(THRESH_RESET);
        @(negedge i_clk);
        offer_tracked(1, 32'h0000_0000, 0);
        offer_tracked(2, 32'hFFFF_FFFF, 0);
        // Wrapped difference one below the threshold, then exactly at it.
        offer_tracked(2, 32'd2998, 0);
        offer_tracked(2, 32'd2999, 0);
        offer_tracked(1, 32'd2999, 0);
        offer_tracked(1, 32'd3000, 0);
        // Tick going backwards wraps to a large interval.
        offer_tracked(1, 32'd2995, 0);
        // Hammered entry: an allowed repeat at the threshold, then an alert.
        offer_tracked(0, pool_last[0] + 32'd3000, 0);
        offer_tracked(0, pool_last[0], 0);
        for (int k = 3; k < ENTRIES_DEF; k++) begin
            offer_tracked(k, $urandom, 0);
        end
        // Table now full: a new key is not stored, so it stays untracked.
        sk = stray_key();
        offer_event(sk, $urandom, 0);
        offer_event(sk, $urandom, 1);
        offer_tracked(ENTRIES_DEF - 1, pool_last[ENTRIES_DEF - 1] + 1'b1, 0);
        wait_drained();

        // Random traffic over several thresholds, the extremes among them.
        random_phase('1, 1'b0);
        random_phase(THRESH_W'(1), 1'b1);
        random_phase('0, 1'b0);
        random_phase(THRESH_W'($urandom_range(2, 20000)), 1'b1);
        random_phase(THRESH_RESET, 1'b0);

        repeat (70) @(negedge i_clk);
        if (verdict_q.size() != 0) faults++;

        $display("Checked %0d of %0d words: %0d new, %0d repeat, %0d alert, %0d untracked.",
                 words_seen, words_sent, verdict_tally[V_NEW], verdict_tally[V_EXISTING],
                 verdict_tally[V_ALERT], verdict_tally[V_UNTRACKED]);
        $display("Thresholds zero, one, default, maximum and random; a %0d-word burst, %0s",
                 HAMMER_WORDS, $sformatf("two %0d-cycle hold-offs.", HOLD_CYCLES));
        if (faults == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pkmim_pkg.sv
hw/rtl/per_key_min_interval_monitor_top.sv
sim/tb_per_key_min_interval_monitor_top.sv
